>>> rtl/crp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_pkg: shared types and constants for the cell range reference parser
// Phase encoding, channel words, character codes and register indexes.
// ----------------------------------------------------------------------------
package crp_pkg;

    localparam int DEF_MAX_COLUMNS = 16384;
    localparam int DEF_MAX_ROWS    = 1048576;

    localparam int CODE_W = 16;
    localparam int OCOL_W = 14;
    localparam int OROW_W = 20;
    localparam int SCOL_W = 15;
    localparam int SROW_W = 21;
    localparam int CFG_W  = 21;

    localparam logic [CODE_W-1:0] CHR_DOLLAR  = 16'h0024;
    localparam logic [CODE_W-1:0] CHR_COLON   = 16'h003A;
    localparam logic [CODE_W-1:0] CHR_ZERO    = 16'h0030;
    localparam logic [CODE_W-1:0] CHR_ONE     = 16'h0031;
    localparam logic [CODE_W-1:0] CHR_NINE    = 16'h0039;
    localparam logic [CODE_W-1:0] CHR_UPPER_A = 16'h0041;
    localparam logic [CODE_W-1:0] CHR_UPPER_Z = 16'h005A;
    localparam logic [CODE_W-1:0] CHR_LOWER_A = 16'h0061;
    localparam logic [CODE_W-1:0] CHR_LOWER_Z = 16'h007A;

    localparam logic CFG_SHEET_WIDTH  = 1'b0;
    localparam logic CFG_SHEET_HEIGHT = 1'b1;

    localparam logic [SCOL_W-1:0] SHEET_WIDTH_RST  = 15'd16384;
    localparam logic [SROW_W-1:0] SHEET_HEIGHT_RST = 21'd1048576;

    typedef enum logic [4:0] {
        PH_START,
        PH_AFTER_D1,
        PH_RO_D1,
        PH_RO1,
        PH_RO_COLON,
        PH_RO_D2,
        PH_RO2,
        PH_COL1,
        PH_CO_COLON,
        PH_CO_D2,
        PH_CO2,
        PH_ROW1_D,
        PH_ROW1,
        PH_AR_COLON,
        PH_AR_D2,
        PH_COL2,
        PH_ROW2_D,
        PH_ROW2,
        PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [CODE_W-1:0] code_unit;
        logic              final_unit;
    } t_in_word;

    typedef struct packed {
        logic              valid_res;
        logic [OCOL_W-1:0] origin_column;
        logic [OROW_W-1:0] origin_row;
        logic [SCOL_W-1:0] span_columns;
        logic [SROW_W-1:0] span_rows;
    } t_res_word;

    // Step control from the top level to the parser core
    typedef struct packed {
        logic step;
        logic last;
    } t_step_ctl;

endpackage

>>> rtl/crp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_stream_if: valid/ready channel
// One word moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface crp_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/cell_range_reference_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_range_reference_parser_unit: A1-style range reference parser
// Streams code units of a reference and gives one rectangle per final unit.
// ----------------------------------------------------------------------------
//  channel   dir   word                                   handshake
//  i_in      in    code_unit, final_unit                  valid/ready
//  o_res     out   valid_res, origin, spans               valid/ready
//  i_cfg_*   in    sheet_width (0), sheet_height (1)      write enable
//
//  One code unit per cycle while i_in.ready is high. The snapshot register
//  takes the parser's next state at the edge that accepts a final unit; the
//  result register then takes the rectangle, and o_res.valid follows it.
//  Reset clears the parser and the valid bits of both stages, and loads the
//  default sheet sizes. A stalled result holds the result register; the
//  snapshot stage absorbs one more final word before i_in.ready drops.
// ----------------------------------------------------------------------------
module cell_range_reference_parser_unit
    import crp_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    crp_stream_if.sink       i_in,
    crp_stream_if.source     o_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int MAXV = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int AW   = $clog2(MAXV + 1);
    localparam int XW   = (AW > SROW_W) ? AW : SROW_W;

    logic [SCOL_W-1:0] r_sheet_width;
    logic [SROW_W-1:0] r_sheet_height;

    t_in_word  in_word;
    t_step_ctl step_ctl;
    logic      accept, out_free, snap_free;

    t_phase        p_phase;
    logic [AW-1:0] p_acc, p_col1, p_row1, p_col2;

    logic          r_snap_valid;
    t_phase        r_snap_phase;
    logic [AW-1:0] r_snap_acc, r_snap_col1, r_snap_row1, r_snap_col2;

    logic      r_res_valid;
    t_res_word r_res, n_res;

    logic [AW-1:0] cur, col_hi_in, ca, cb, ra, rb;
    logic [XW-1:0] ca_x, cur_x, ra_x, col1_x, col_span, row_span;

    assign in_word   = i_in.data;
    assign out_free  = !r_res_valid || o_res.ready;
    assign snap_free = !r_snap_valid || out_free;
    assign accept    = i_in.valid && snap_free;
    assign i_in.ready = snap_free;

    assign step_ctl.step = accept;
    assign step_ctl.last = in_word.final_unit;

    crp_parser #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .AW          (AW)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (step_ctl),
        .i_code  (in_word.code_unit),
        .o_phase (p_phase),
        .o_acc   (p_acc),
        .o_col1  (p_col1),
        .o_row1  (p_row1),
        .o_col2  (p_col2)
    );

    // sheet size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sheet_width  <= SHEET_WIDTH_RST;
            r_sheet_height <= SHEET_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHEET_WIDTH:  r_sheet_width  <= i_cfg_data[SCOL_W-1:0];
                CFG_SHEET_HEIGHT: r_sheet_height <= i_cfg_data[SROW_W-1:0];
                default: ;
            endcase
        end
    end

    // snapshot of the parser state after a final unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (snap_free) begin
            r_snap_valid <= accept && in_word.final_unit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_word.final_unit) begin
            r_snap_phase <= p_phase;
            r_snap_acc   <= p_acc;
            r_snap_col1  <= p_col1;
            r_snap_row1  <= p_row1;
            r_snap_col2  <= p_col2;
        end
    end

    // order each pair and form the rectangle
    always_comb begin
        cur       = r_snap_acc - AW'(1);
        col_hi_in = (r_snap_phase == PH_CO2) ? cur : r_snap_col2;
        if (r_snap_col1 > col_hi_in) begin
            ca = col_hi_in;
            cb = r_snap_col1;
        end else begin
            ca = r_snap_col1;
            cb = col_hi_in;
        end
        if (r_snap_row1 > cur) begin
            ra = cur;
            rb = r_snap_row1;
        end else begin
            ra = r_snap_row1;
            rb = cur;
        end
        ca_x     = XW'(ca);
        ra_x     = XW'(ra);
        cur_x    = XW'(cur);
        col1_x   = XW'(r_snap_col1);
        col_span = XW'(cb) - ca_x + XW'(1);
        row_span = XW'(rb) - ra_x + XW'(1);

        n_res = '0;
        case (r_snap_phase)
            PH_RO2: begin
                n_res.valid_res    = 1'b1;
                n_res.origin_row   = ra_x[OROW_W-1:0];
                n_res.span_columns = r_sheet_width;
                n_res.span_rows    = row_span[SROW_W-1:0];
            end
            PH_CO2: begin
                n_res.valid_res     = 1'b1;
                n_res.origin_column = ca_x[OCOL_W-1:0];
                n_res.span_columns  = col_span[SCOL_W-1:0];
                n_res.span_rows     = r_sheet_height;
            end
            PH_ROW1: begin
                n_res.valid_res     = 1'b1;
                n_res.origin_column = col1_x[OCOL_W-1:0];
                n_res.origin_row    = cur_x[OROW_W-1:0];
                n_res.span_columns  = SCOL_W'(1);
                n_res.span_rows     = SROW_W'(1);
            end
            PH_ROW2: begin
                n_res.valid_res     = 1'b1;
                n_res.origin_column = ca_x[OCOL_W-1:0];
                n_res.origin_row    = ra_x[OROW_W-1:0];
                n_res.span_columns  = col_span[SCOL_W-1:0];
                n_res.span_rows     = row_span[SROW_W-1:0];
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (out_free) begin
            r_res_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_snap_valid) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

endmodule

>>> rtl/crp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_parser: reference text state machine
// Holds parse phase, number accumulator and the captured bounds; gives the
// values after the current code unit so the caller can snapshot a final word.
// ----------------------------------------------------------------------------
module crp_parser
    import crp_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int AW          = 21
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_step_ctl         i_ctl,
    input  logic [CODE_W-1:0] i_code,
    output t_phase            o_phase,
    output logic [AW-1:0]     o_acc,
    output logic [AW-1:0]     o_col1,
    output logic [AW-1:0]     o_row1,
    output logic [AW-1:0]     o_col2
);

    localparam int PW = AW + 5;

    t_phase        r_phase, n_phase;
    logic [AW-1:0] r_acc, n_acc;
    logic [AW-1:0] r_col1, n_col1;
    logic [AW-1:0] r_row1, n_row1;
    logic [AW-1:0] r_col2, n_col2;

    logic              is_upper, is_lower, is_letter, is_digit, is_lead;
    logic              is_dollar, is_colon;
    logic [CODE_W-1:0] lv_full, dig_full;
    logic [4:0]        lv;
    logic [3:0]        dig;
    logic [AW-1:0]     lv_acc, dig_acc, acc_m1;
    logic [PW-1:0]     prod_c, prod_r;
    logic              ovf_c, ovf_r;

    always_comb begin
        is_upper  = (i_code >= CHR_UPPER_A) && (i_code <= CHR_UPPER_Z);
        is_lower  = (i_code >= CHR_LOWER_A) && (i_code <= CHR_LOWER_Z);
        is_letter = is_upper || is_lower;
        is_digit  = (i_code >= CHR_ZERO) && (i_code <= CHR_NINE);
        is_lead   = (i_code >= CHR_ONE) && (i_code <= CHR_NINE);
        is_dollar = (i_code == CHR_DOLLAR);
        is_colon  = (i_code == CHR_COLON);
        lv_full   = is_upper ? (i_code - CHR_UPPER_A + 16'd1) : (i_code - CHR_LOWER_A + 16'd1);
        dig_full  = i_code - CHR_ZERO;
        lv        = lv_full[4:0];
        dig       = dig_full[3:0];
        lv_acc    = AW'(lv);
        dig_acc   = AW'(dig);
        acc_m1    = r_acc - AW'(1);
        // base 26 / base 10 step with range check against the grid size
        prod_c    = PW'(r_acc) * PW'(26) + PW'(lv);
        prod_r    = PW'(r_acc) * PW'(10) + PW'(dig);
        ovf_c     = prod_c > PW'(MAX_COLUMNS);
        ovf_r     = prod_r > PW'(MAX_ROWS);
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_col1  = r_col1;
        n_row1  = r_row1;
        n_col2  = r_col2;
        case (r_phase)
            PH_START: begin
                if (is_dollar) begin
                    n_phase = PH_AFTER_D1;
                end else if (is_letter) begin
                    n_acc   = lv_acc;
                    n_phase = PH_COL1;
                end else if (is_lead) begin
                    n_acc   = dig_acc;
                    n_phase = PH_RO1;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_AFTER_D1: begin
                if (is_letter) begin
                    n_acc   = lv_acc;
                    n_phase = PH_COL1;
                end else if (is_dollar) begin
                    // failed column attempt already took one dollar
                    n_phase = PH_RO_D1;
                end else if (is_lead) begin
                    n_acc   = dig_acc;
                    n_phase = PH_RO1;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_RO_D1: begin
                if (is_lead) begin
                    n_acc   = dig_acc;
                    n_phase = PH_RO1;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_RO1: begin
                if (is_digit) begin
                    if (ovf_r) n_phase = PH_ERROR;
                    else       n_acc   = prod_r[AW-1:0];
                end else if (is_colon) begin
                    n_row1  = acc_m1;
                    n_phase = PH_RO_COLON;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_RO_COLON: begin
                if (is_dollar) begin
                    n_phase = PH_RO_D2;
                end else if (is_lead) begin
                    n_acc   = dig_acc;
                    n_phase = PH_RO2;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_RO_D2: begin
                if (is_lead) begin
                    n_acc   = dig_acc;
                    n_phase = PH_RO2;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_RO2, PH_ROW2: begin
                if (is_digit) begin
                    if (ovf_r) n_phase = PH_ERROR;
                    else       n_acc   = prod_r[AW-1:0];
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_ROW1: begin
                if (is_digit) begin
                    if (ovf_r) n_phase = PH_ERROR;
                    else       n_acc   = prod_r[AW-1:0];
                end else if (is_colon) begin
                    n_row1  = acc_m1;
                    n_phase = PH_AR_COLON;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_COL1: begin
                if (is_letter) begin
                    if (ovf_c) n_phase = PH_ERROR;
                    else       n_acc   = prod_c[AW-1:0];
                end else begin
                    n_col1 = acc_m1;
                    if (is_colon) begin
                        n_phase = PH_CO_COLON;
                    end else if (is_dollar) begin
                        n_phase = PH_ROW1_D;
                    end else if (is_lead) begin
                        n_acc   = dig_acc;
                        n_phase = PH_ROW1;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
            end
            PH_CO_COLON: begin
                if (is_dollar) begin
                    n_phase = PH_CO_D2;
                end else if (is_letter) begin
                    n_acc   = lv_acc;
                    n_phase = PH_CO2;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_CO_D2: begin
                if (is_letter) begin
                    n_acc   = lv_acc;
                    n_phase = PH_CO2;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_CO2, PH_COL2: begin
                if (is_letter) begin
                    if (ovf_c) n_phase = PH_ERROR;
                    else       n_acc   = prod_c[AW-1:0];
                end else if (r_phase == PH_CO2) begin
                    n_phase = PH_ERROR;
                end else begin
                    n_col2 = acc_m1;
                    if (is_dollar) begin
                        n_phase = PH_ROW2_D;
                    end else if (is_lead) begin
                        n_acc   = dig_acc;
                        n_phase = PH_ROW2;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
            end
            PH_ROW1_D: begin
                if (is_lead) begin
                    n_acc   = dig_acc;
                    n_phase = PH_ROW1;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_AR_COLON: begin
                if (is_dollar) begin
                    n_phase = PH_AR_D2;
                end else if (is_letter) begin
                    n_acc   = lv_acc;
                    n_phase = PH_COL2;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_AR_D2: begin
                if (is_letter) begin
                    n_acc   = lv_acc;
                    n_phase = PH_COL2;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_ROW2_D: begin
                if (is_lead) begin
                    n_acc   = dig_acc;
                    n_phase = PH_ROW2;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_acc   <= '0;
            r_col1  <= '0;
            r_row1  <= '0;
            r_col2  <= '0;
        end else if (i_ctl.step) begin
            if (i_ctl.last) begin
                // start over for the next reference
                r_phase <= PH_START;
                r_acc   <= '0;
                r_col1  <= '0;
                r_row1  <= '0;
                r_col2  <= '0;
            end else begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_col1  <= n_col1;
                r_row1  <= n_row1;
                r_col2  <= n_col2;
            end
        end
    end

    assign o_phase = n_phase;
    assign o_acc   = n_acc;
    assign o_col1  = n_col1;
    assign o_row1  = n_row1;
    assign o_col2  = n_col2;

endmodule
